>>> design/dq_pkg.sv
// Shared types, codes and default sizes for the double-ended queue.
`default_nettype none

package dq_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  localparam int FUNC_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  typedef enum logic [FUNC_W-1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_RESULT = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic exec;
  } cmd_t;

endpackage

`default_nettype wire

>>> design/dq_if.sv
// Request and response channel interfaces of the double-ended queue.
`default_nettype none

interface dq_req_if;
  logic                               valid;
  logic                               ready;
  logic        [dq_pkg::FUNC_W-1:0]   func;
  logic signed [dq_pkg::VALUE_W-1:0]  push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface dq_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [dq_pkg::VALUE_W-1:0]  pop_value;
  logic        [dq_pkg::STATUS_W-1:0] status;
  logic        [dq_pkg::FILL_W-1:0]   fill_level;

  modport source (output valid, output pop_value, output status, output fill_level,
                  input ready);
  modport sink   (input valid, input pop_value, input status, input fill_level,
                  output ready);
endinterface

`default_nettype wire

>>> design/dq_ctrl.sv
// Handshake controller: takes one word, then holds the result until it is taken.
`default_nettype none

module dq_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         req_valid,
  output      logic         req_ready,
  output      logic         rsp_valid,
  input  wire logic         rsp_ready,
  output      dq_pkg::cmd_t cmd
);

  dq_pkg::state_t state;
  dq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dq_pkg::S_IDLE: begin
        if (req_valid) state_next = dq_pkg::S_RESULT;
      end
      dq_pkg::S_RESULT: begin
        if (rsp_ready) state_next = dq_pkg::S_IDLE;
      end
      default: state_next = dq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    rsp_valid = 1'b0;
    cmd.exec  = 1'b0;
    unique case (state)
      dq_pkg::S_IDLE: begin
        req_ready = 1'b1;
        cmd.exec  = req_valid;
      end
      dq_pkg::S_RESULT: begin
        rsp_valid = 1'b1;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/dq_datapath.sv
// Circular store with head and tail pointers, fill count and result registers.
`default_nettype none

module dq_datapath #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire dq_pkg::cmd_t                       cmd,
  input  wire logic        [dq_pkg::FUNC_W-1:0]   func,
  input  wire logic signed [dq_pkg::VALUE_W-1:0]  push_value,
  output      logic signed [dq_pkg::VALUE_W-1:0]  pop_value,
  output      logic        [dq_pkg::STATUS_W-1:0] status,
  output      logic        [dq_pkg::FILL_W-1:0]   fill_level
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic signed [DATA_WIDTH-1:0] mem [DEPTH];

  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] count, count_next;

  logic signed [DATA_WIDTH-1:0] rdata;
  logic                         pop_ok, pop_ok_next;
  dq_pkg::status_t              res_status, res_status_next;

  dq_pkg::op_t      op;
  logic             full, empty, is_push;
  logic [PTR_W-1:0] head_inc, head_dec, tail_dec, tail_inc;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr, rd_addr;
  logic signed [DATA_WIDTH-1:0] word;

  assign op      = dq_pkg::op_t'(func);
  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign is_push = (op == dq_pkg::OP_PUSH_BACK) || (op == dq_pkg::OP_PUSH_FRONT);
  assign word    = DATA_WIDTH'(push_value);

  // pointers wrap at DEPTH, which need not be a power of two
  assign head_inc = (head == LAST) ? '0 : head + PTR_W'(1);
  assign head_dec = (head == '0) ? LAST : head - PTR_W'(1);
  assign tail_inc = (tail == LAST) ? '0 : tail + PTR_W'(1);
  assign tail_dec = (tail == '0) ? LAST : tail - PTR_W'(1);

  always_comb begin
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    wr_en           = 1'b0;
    wr_addr         = tail;
    rd_addr         = head;
    pop_ok_next     = 1'b0;
    res_status_next = dq_pkg::ST_OK;
    unique case (op)
      dq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          res_status_next = dq_pkg::ST_FULL;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = tail;
          tail_next  = tail_inc;
          count_next = count + CNT_W'(1);
        end
      end
      dq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          res_status_next = dq_pkg::ST_FULL;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = head_dec;
          head_next  = head_dec;
          count_next = count + CNT_W'(1);
        end
      end
      dq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          res_status_next = dq_pkg::ST_EMPTY;
        end else begin
          rd_addr     = head;
          pop_ok_next = 1'b1;
          head_next   = head_inc;
          count_next  = count - CNT_W'(1);
        end
      end
      dq_pkg::OP_POP_BACK: begin
        if (empty) begin
          res_status_next = dq_pkg::ST_EMPTY;
        end else begin
          rd_addr     = tail_dec;
          pop_ok_next = 1'b1;
          tail_next   = tail_dec;
          count_next  = count - CNT_W'(1);
        end
      end
      default: res_status_next = dq_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (wr_en) mem[wr_addr] <= word;
      rdata      <= mem[rd_addr];
      pop_ok     <= pop_ok_next;
      res_status <= res_status_next;
    end
  end

  assign pop_value  = pop_ok ? dq_pkg::VALUE_W'(rdata) : '0;
  assign status     = res_status;
  assign fill_level = dq_pkg::FILL_W'(count);

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("fill count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (head == tail))
    else $error("pointers differ on an empty queue");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && is_push && !full) |=> (count == $past(count) + CNT_W'(1)))
    else $error("accepted push did not add an entry");

  a_refused_holds: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && ((is_push && full) || (!is_push && empty)))
      |=> (count == $past(count)) && (head == $past(head)) && (tail == $past(tail)))
    else $error("refused word changed the queue");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !cmd.exec |=> $stable(count) && $stable(head) && $stable(tail))
    else $error("queue state moved without a word");
`endif

endmodule

`default_nettype wire

>>> design/double_ended_queue.sv
// Top level of the bounded double-ended queue of signed words.
// Usage:
//   req carries one word per handshake: func (0 push back, 1 push front,
//   2 pop front, 3 pop back) and push_value. rsp returns exactly one word per
//   request: pop_value (zero unless a pop succeeded), status (0 ok, 1 full,
//   2 empty) and fill_level, the entry count after the operation.
//   Entries live in a DEPTH-deep circular store with head and tail pointers;
//   the read port of that store is registered.
//   Responses are registered: a taken request loads the result registers and
//   moves the controller to the result state, which drives rsp.valid.
//   With one result register, no new request is taken until the response is.
//   A stalled response holds steady and req.ready stays low until it is taken.
//   Reset (rst, synchronous) empties the queue and drops any pending response;
//   store contents are not cleared and are never returned before being written.
`default_nettype none

module double_ended_queue #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = dq_pkg::DATA_WIDTH_DEFAULT
) (
  input wire logic clk,
  input wire logic rst,
  dq_req_if.sink   req,
  dq_rsp_if.source rsp
);

  dq_pkg::cmd_t cmd;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  dq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .func       (req.func),
    .push_value (req.push_value),
    .pop_value  (rsp.pop_value),
    .status     (rsp.status),
    .fill_level (rsp.fill_level)
  );

endmodule

`default_nettype wire
